### sv/sscr_pkg.sv
`timescale 1ns / 1ps

package sscr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int AXIS_W        = 16;
  localparam int DIAG_W        = 7;
  // c/b of the gain root stays below 2^RATIO_BITS (max 100^2)
  localparam int RATIO_BITS    = 14;
  // width of the root operands c and b
  localparam int OPND_W        = 44;

  localparam logic [DIAG_W-1:0] DIAG_RESET = 7'd100;
  localparam logic [12:0]       CORNER_NUM = 13'd5000;

  localparam logic REG_DIAG = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic signed [AXIS_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [AXIS_W-1:0] OUT_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } side_t;

endpackage

### sv/stick_square_circle_remap.sv
`timescale 1ns / 1ps

// Stick radius remap, fully pipelined.
// Input: an item (stick_x, stick_y) is taken at a clock edge with start high
// and busy low. busy is high only while rst is asserted.
// Output: done strobes for one cycle with out_x/out_y; the receiver cannot
// stall, so nothing ever backs up into the pipe.
// Config: cfg_we/cfg_index/cfg_data write diagonal_percent (index 0) or
// square_mode (index 1, bit 0); change them only with the pipe empty.
// Throughput: one item per cycle.
// Pipeline: the front end, the divider (one quotient bit per stage), the square
// root (one root bit per stage), then the scale and the saturate registers.
// Reset clears all valid bits and loads diagonal 100, circle mode.
module stick_square_circle_remap #(
  parameter int FRAC_BITS = sscr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sscr_pkg::AXIS_W-1:0]  stick_x,
  input  logic signed [sscr_pkg::AXIS_W-1:0]  stick_y,
  output logic                                done,
  output logic signed [sscr_pkg::AXIS_W-1:0]  out_x,
  output logic signed [sscr_pkg::AXIS_W-1:0]  out_y,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sscr_pkg::DIAG_W-1:0]         cfg_data
);
  import sscr_pkg::*;

  localparam int QW  = 2*FRAC_BITS + RATIO_BITS;
  localparam int RW  = QW / 2;
  localparam int PW  = AXIS_W + RW + 1;
  localparam int LAT = 5 + QW + RW + 2;

  logic [DIAG_W-1:0] diag;
  logic              sq_mode;
  logic              take;

  assign busy = rst;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      diag    <= DIAG_RESET;
      sq_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIAG: diag    <= cfg_data;
        REG_MODE: sq_mode <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // front end: magnitudes, squares and the corner test
  logic              v1, v2, v3, v4, v5;
  side_t             sd1, sd2, sd3, sd4, sd5;
  logic [AXIS_W-1:0] ax1, ay1, m1;
  logic [DIAG_W-1:0] p1;
  logic [31:0]       ax2, ay2, m2;
  logic [2*DIAG_W-1:0] p2;
  logic [31:0]       q3, m3;
  logic [OPND_W-1:0] pm3, pm4, q5x4;
  logic [31:0]       q4, m4;
  logic [2*DIAG_W-1:0] p3, p4;
  logic [OPND_W-1:0] num5, den5;
  logic [AXIS_W-1:0] ax_c, ay_c;
  logic              corner_less;

  assign ax_c = stick_x[AXIS_W-1] ? (~stick_x + 1'b1) : stick_x;
  assign ay_c = stick_y[AXIS_W-1] ? (~stick_y + 1'b1) : stick_y;
  assign corner_less = pm4 < q5x4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    sd1 <= '{x: stick_x, y: stick_y};
    ax1 <= ax_c;
    ay1 <= ay_c;
    m1  <= (ax_c > ay_c) ? ax_c : ay_c;
    p1  <= (diag == '0) ? DIAG_W'(1) : diag;

    sd2 <= sd1;
    ax2 <= 32'(ax1) * 32'(ax1);
    ay2 <= 32'(ay1) * 32'(ay1);
    m2  <= 32'(m1) * 32'(m1);
    p2  <= (2*DIAG_W)'(p1) * (2*DIAG_W)'(p1);

    sd3 <= sd2;
    q3  <= ax2 + ay2;
    m3  <= m2;
    p3  <= p2;
    pm3 <= OPND_W'(p2) * OPND_W'(m2);

    sd4  <= sd3;
    q4   <= q3;
    m4   <= m3;
    p4   <= p3;
    pm4  <= pm3;
    q5x4 <= OPND_W'(q3) * OPND_W'(CORNER_NUM);

    // gain^2 = num / den
    sd5 <= sd4;
    if (sq_mode) begin
      num5 <= corner_less ? q5x4 : OPND_W'(1);
      den5 <= corner_less ? pm4  : OPND_W'(1);
    end else begin
      num5 <= corner_less ? OPND_W'(CORNER_NUM) : OPND_W'(m4);
      den5 <= corner_less ? OPND_W'(p4)         : OPND_W'(q4);
    end
  end

  logic          dv_v;
  logic [QW-1:0] dq;
  side_t         dsd;

  sscr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (v5),
    .num      (num5),
    .den      (den5),
    .side_in  (sd5),
    .vld_out  (dv_v),
    .quot     (dq),
    .side_out (dsd)
  );

  logic          sq_v;
  logic [RW-1:0] gain;
  side_t         ssd;

  sscr_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (dv_v),
    .rad_in   (dq),
    .side_in  (dsd),
    .vld_out  (sq_v),
    .root     (gain),
    .side_out (ssd)
  );

  // back end: scale, floor, saturate
  logic                 vm;
  logic signed [PW-1:0] px, py, shx, shy;

  assign shx = px >>> FRAC_BITS;
  assign shy = py >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm   <= 1'b0;
      done <= 1'b0;
    end else begin
      vm   <= sq_v;
      done <= vm;
    end
    px <= PW'(ssd.x) * PW'($signed({1'b0, gain}));
    py <= PW'(ssd.y) * PW'($signed({1'b0, gain}));
    if (shx > PW'(OUT_MAX))      out_x <= OUT_MAX;
    else if (shx < PW'(OUT_MIN)) out_x <= OUT_MIN;
    else                         out_x <= shx[AXIS_W-1:0];
    if (shy > PW'(OUT_MAX))      out_y <= OUT_MAX;
    else if (shy < PW'(OUT_MIN)) out_y <= OUT_MIN;
    else                         out_y <= shy[AXIS_W-1:0];
  end

  a_lat: assert property (@(posedge clk) disable iff (rst)
    take |-> ##LAT done)
    else $error("accepted item gave no result strobe");

  a_only: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, LAT))
    else $error("result strobe without an accepted item");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(take && stick_x == '0 && stick_y == '0, LAT)
      |-> out_x == '0 && out_y == '0)
    else $error("zero vector gave nonzero result");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    done && $past(take && !stick_x[AXIS_W-1], LAT) |-> !out_x[AXIS_W-1])
    else $error("sign of out_x flipped");

endmodule

### sv/sscr_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// quot = floor(c * 2^(2*FRAC_BITS) / b), valid for c < b * 2^RATIO_BITS.
module sscr_div #(
  parameter int FRAC_BITS = sscr_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   vld_in,
  input  logic [sscr_pkg::OPND_W-1:0]            num,
  input  logic [sscr_pkg::OPND_W-1:0]            den,
  input  sscr_pkg::side_t                        side_in,
  output logic                                   vld_out,
  output logic [2*FRAC_BITS+sscr_pkg::RATIO_BITS-1:0] quot,
  output sscr_pkg::side_t                        side_out
);
  import sscr_pkg::*;

  localparam int QW = 2*FRAC_BITS + RATIO_BITS;
  localparam int DW = OPND_W + RATIO_BITS;

  logic [DW-1:0]     rem  [QW+1];
  logic [OPND_W-1:0] dv   [QW+1];
  logic [QW-1:0]     quo  [QW+1];
  logic              vld  [QW+1];
  side_t             sd   [QW+1];

  assign rem[0] = DW'(num);
  assign dv[0]  = den;
  assign quo[0] = '0;
  assign vld[0] = vld_in;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] sft;
    logic [DW:0] dsh;
    logic        ge;

    assign sft = {rem[i], 1'b0};
    assign dsh = {1'b0, dv[i], RATIO_BITS'(0)};
    assign ge  = (sft >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1] <= ge ? DW'(sft - dsh) : DW'(sft);
      dv[i+1]  <= dv[i];
      quo[i+1] <= {quo[i][QW-2:0], ge};
      sd[i+1]  <= sd[i];
    end
  end

  assign vld_out  = vld[QW];
  assign quot     = quo[QW];
  assign side_out = sd[QW];

endmodule

### sv/sscr_sqrt.sv
`timescale 1ns / 1ps

// Pipelined digit-by-digit integer square root, one root bit per stage.
module sscr_sqrt #(
  parameter int FRAC_BITS = sscr_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        vld_in,
  input  logic [2*FRAC_BITS+sscr_pkg::RATIO_BITS-1:0] rad_in,
  input  sscr_pkg::side_t                             side_in,
  output logic                                        vld_out,
  output logic [FRAC_BITS+sscr_pkg::RATIO_BITS/2-1:0] root,
  output sscr_pkg::side_t                             side_out
);
  import sscr_pkg::*;

  localparam int QW  = 2*FRAC_BITS + RATIO_BITS;
  localparam int RW  = QW / 2;
  localparam int RMW = RW + 2;

  logic [QW-1:0]  rad  [RW+1];
  logic [RMW-1:0] rem  [RW+1];
  logic [RW-1:0]  rt   [RW+1];
  logic           vld  [RW+1];
  side_t          sd   [RW+1];

  assign rad[0] = rad_in;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign vld[0] = vld_in;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RMW-1:0] sh;
    logic [RMW-1:0] trial;
    logic           ge;

    assign sh    = {rem[j][RMW-3:0], rad[j][QW-1-2*j -: 2]};
    assign trial = {rt[j], 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      rad[j+1] <= rad[j];
      rem[j+1] <= ge ? (sh - trial) : sh;
      rt[j+1]  <= {rt[j][RW-2:0], ge};
      sd[j+1]  <= sd[j];
    end
  end

  assign vld_out  = vld[RW];
  assign root     = rt[RW];
  assign side_out = sd[RW];

endmodule

### verif/tb_stick_square_circle_remap.sv
`timescale 1ns / 1ps

module tb_stick_square_circle_remap;
  import sscr_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int GAIN_INT = 7;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic {ENT_ITEM, ENT_CFG} ent_kind_t;

  typedef struct {
    ent_kind_t kind;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic idx;
    logic [DIAG_W-1:0] data;
  } entry_t;

  typedef struct {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } remap_t;

  logic clk, rst, start, busy, done, cfg_we, cfg_index;
  logic signed [AXIS_W-1:0] stick_x, stick_y, out_x, out_y;
  logic [DIAG_W-1:0] cfg_data;

  entry_t pending_q[$];
  remap_t remap_exp_q[$];
  logic [DIAG_W-1:0] diag_model;
  logic mode_model;
  int errors = 0;
  int cycles = 0;
  int gap = 0;

  stick_square_circle_remap uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .stick_x(stick_x), .stick_y(stick_y),
    .done(done), .out_x(out_x), .out_y(out_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // largest g with g*g*b <= c * 2^(2*FB)
  function automatic logic [127:0] gain_root(logic [127:0] b, logic [127:0] c);
    logic [127:0] g, t;
    g = '0;
    for (int k = FB + GAIN_INT; k >= 0; k--) begin
      t = g | (128'd1 << k);
      if (t * t * b <= (c << (2 * FB))) g = t;
    end
    return g;
  endfunction

  function automatic logic signed [AXIS_W-1:0] scale_axis(logic signed [AXIS_W-1:0] a,
                                                          logic [127:0] g);
    longint p, r;
    p = longint'(a) * longint'(g[40:0]);
    r = p >>> FB;  // floor
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[AXIS_W-1:0];
  endfunction

  function automatic remap_t predict_remap(logic signed [AXIS_W-1:0] x,
                                           logic signed [AXIS_W-1:0] y);
    logic [127:0] ax, ay, m, q, p, g, pm;
    remap_t r;
    ax = x < 0 ? 128'(-longint'(x)) : 128'(longint'(x));
    ay = y < 0 ? 128'(-longint'(y)) : 128'(longint'(y));
    m = ax > ay ? ax : ay;
    q = ax * ax + ay * ay;
    p = diag_model == 0 ? 128'd1 : 128'(diag_model);
    if (m == 0) begin
      r.x = '0;
      r.y = '0;
      return r;
    end
    pm = 2 * p * p * m * m;
    if (mode_model) begin
      g = (pm < 10000 * q) ? gain_root(pm, 10000 * q) : (128'd1 << FB);
    end else begin
      g = (pm < 10000 * q) ? gain_root(2 * p * p, 10000) : gain_root(q, m * m);
    end
    r.x = scale_axis(x, g);
    r.y = scale_axis(y, g);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    logic n_start, n_we;
    entry_t e;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      stick_x <= '0;
      stick_y <= '0;
      cfg_index <= REG_DIAG;
      cfg_data <= '0;
      diag_model = DIAG_RESET;
      mode_model = 1'b0;
      gap = 0;
    end else begin
      n_start = start;
      n_we = 1'b0;
      if (start && !busy) begin
        remap_exp_q.insert(remap_exp_q.size(), predict_remap(stick_x, stick_y));
        n_start = 1'b0;
      end
      if (!(start && busy)) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_q.size() > 0) begin
          e = pending_q[0];
          if (e.kind == ENT_ITEM) begin
            void'(pending_q.pop_front());
            n_start = 1'b1;
            stick_x <= e.x;
            stick_y <= e.y;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end else if (remap_exp_q.size() == 0 && !(start && !busy)) begin
            void'(pending_q.pop_front());
            n_we = 1'b1;
            cfg_index <= e.idx;
            cfg_data <= e.data;
            if (e.idx == REG_DIAG) diag_model = e.data;
            else mode_model = e.data[0];
          end
        end
      end
      start <= n_start;
      cfg_we <= n_we;
    end
  end

  // monitor
  always @(posedge clk) begin
    remap_t exp_r;
    if (!rst && done) begin
      if (remap_exp_q.size() == 0) begin
        $error("unexpected result out_x=%0d out_y=%0d", out_x, out_y);
        errors++;
      end else begin
        exp_r = remap_exp_q.pop_front();
        if (out_x !== exp_r.x) begin
          $error("out_x expected %0d actual %0d", exp_r.x, out_x);
          errors++;
        end
        if (out_y !== exp_r.y) begin
          $error("out_y expected %0d actual %0d", exp_r.y, out_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("stick_square_circle_remap test failed");
      $finish;
    end
  end

  task automatic add_item(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y);
    entry_t e;
    e.kind = ENT_ITEM;
    e.x = x;
    e.y = y;
    e.idx = REG_DIAG;
    e.data = '0;
    pending_q.insert(pending_q.size(), e);
  endtask

  task automatic add_cfg(logic idx, logic [DIAG_W-1:0] data);
    entry_t e;
    e.kind = ENT_CFG;
    e.x = '0;
    e.y = '0;
    e.idx = idx;
    e.data = data;
    pending_q.insert(pending_q.size(), e);
  endtask

  task automatic add_random(int n);
    logic signed [AXIS_W-1:0] x, y;
    int d;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          x = AXIS_W'($urandom);
          y = AXIS_W'($urandom);
        end
        1: begin  // small magnitudes
          x = AXIS_W'($signed($urandom_range(0, 64)) - 32);
          y = AXIS_W'($signed($urandom_range(0, 64)) - 32);
        end
        2: begin  // near an axis
          x = AXIS_W'($urandom);
          y = AXIS_W'($signed($urandom_range(0, 200)) - 100);
          if ($urandom_range(0, 1)) {x, y} = {y, x};
        end
        3: begin  // near the diagonal
          x = AXIS_W'($urandom);
          d = $urandom_range(0, 400);
          y = x + 16'(d) - 16'sd200;
          if ($urandom_range(0, 1)) y = -y;
        end
        default: begin  // rail values
          x = $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
          y = AXIS_W'($urandom);
        end
      endcase
      add_item(x, y);
    end
  endtask

  initial begin
    logic [DIAG_W-1:0] diag_set[9];
    logic mode_set[9];
    rst = 1;
    diag_set = '{7'd100, 7'd100, 7'd0, 7'd0, 7'd1, 7'd127, 7'd127, 7'd70, 7'd85};
    mode_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    // directed items at reset settings (diagonal 100, circle mode), then in square mode and with diagonal 0
    add_item(16'sd0, 16'sd0);
    add_item(OUT_MIN, OUT_MIN);
    add_item(OUT_MAX, OUT_MAX);
    add_item(OUT_MIN, OUT_MAX);
    add_item(OUT_MAX, 16'sd0);
    add_item(16'sd0, OUT_MIN);
    add_item(-16'sd1, -16'sd1);
    add_item(16'sd1, 16'sd0);
    add_item(-16'sd1, 16'sd1);
    add_item(16'sd20000, -16'sd20000);
    add_item(16'sd30000, 16'sd12345);
    add_item(16'sh5555, 16'shAAAA);
    add_cfg(REG_MODE, 7'd1);
    add_item(OUT_MIN, OUT_MIN);
    add_item(OUT_MAX, -16'sd100);
    add_item(-16'sd3, 16'sd7);
    add_cfg(REG_DIAG, 7'd0);
    add_item(OUT_MAX, OUT_MAX);
    add_item(OUT_MIN, 16'sd1);
    add_item(16'sd0, 16'sd0);

    for (int ph = 0; ph < 9; ph++) begin
      add_cfg(REG_DIAG, diag_set[ph]);
      add_cfg(REG_MODE, DIAG_W'(mode_set[ph]));
      add_random(120);
    end
    for (int ph = 0; ph < 4; ph++) begin
      add_cfg(REG_DIAG, DIAG_W'($urandom_range(0, 127)));
      add_cfg(REG_MODE, DIAG_W'($urandom_range(0, 1)));
      add_random(120);
    end

    repeat (9) @(posedge clk);
    rst <= 0;
    while (pending_q.size() > 0 || remap_exp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && remap_exp_q.size() == 0) begin
      $display("stick_square_circle_remap test passed");
    end else begin
      $display("stick_square_circle_remap test failed");
    end
    $finish;
  end

endmodule
